@@ rtl/core/assert_macros.svh @@
// assertion helpers used by lrgd_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/core/lrgd_pkg.sv @@
// ----------------------------------------------------------------------------
// lrgd_pkg
// types, codes and fixed-point helpers of the gradient descent trainer
// ----------------------------------------------------------------------------
package lrgd_pkg;

    // input transaction
    typedef struct packed {
        logic signed [31:0] feature_value;
        logic signed [31:0] target_value;
        logic               set_end;
    } t_item;

    // result transaction
    typedef struct packed {
        logic signed [31:0] coefficient;
        logic [3:0]         coefficient_index;
        logic               last;
    } t_result;

    // register indexes
    localparam logic [1:0] CFG_LEARNING_RATE = 2'd0;
    localparam logic [1:0] CFG_EPOCH_COUNT   = 2'd1;
    localparam logic [1:0] CFG_FEATURE_COUNT = 2'd2;

    localparam logic [15:0] LR_RESET    = 16'd655;
    localparam logic [15:0] EPOCH_RESET = 16'd100;
    localparam logic [3:0]  FC_RESET    = 4'd1;

    // datapath operations
    typedef logic [3:0] t_op;
    localparam t_op OP_IDLE  = 4'd0;
    localparam t_op OP_INIT  = 4'd1;
    localparam t_op OP_P_RD  = 4'd2;
    localparam t_op OP_P_MUL = 4'd3;
    localparam t_op OP_P_ACC = 4'd4;
    localparam t_op OP_G_RD  = 4'd5;
    localparam t_op OP_G_ERR = 4'd6;
    localparam t_op OP_G_MUL = 4'd7;
    localparam t_op OP_G_ACC = 4'd8;
    localparam t_op OP_DIV   = 4'd9;
    localparam t_op OP_STEP  = 4'd10;
    localparam t_op OP_UPD   = 4'd11;
    localparam t_op OP_EMIT  = 4'd12;

    typedef struct packed {
        t_op  op;
        logic load;
        logic div_start;
    } t_cmd;

    typedef struct packed {
        logic row_last;
        logic col_last;
        logic col_bias;
        logic epoch_last;
        logic set_empty;
        logic epochs_zero;
        logic div_done;
    } t_status;

    // saturate a 33 bit sum to 32 bits
    function automatic logic signed [31:0] sat33(input logic signed [32:0] s);
        if (s[32] != s[31]) begin
            return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        return s[31:0];
    endfunction

    // saturating add
    function automatic logic signed [31:0] sadd(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        return sat33(s);
    endfunction

    // Q16.16 product rescale: floor shift by 16, saturate
    function automatic logic signed [31:0] qsat(input logic signed [63:0] p);
        logic signed [47:0] sh;
        sh = p[63:16];
        if (!sh[47] && (|sh[46:31])) begin
            return 32'sh7fff_ffff;
        end
        if (sh[47] && !(&sh[46:31])) begin
            return 32'sh8000_0000;
        end
        return sh[31:0];
    endfunction

endpackage

@@ rtl/core/linear_regression_gd_trainer.sv @@
// loading: one feature value per cycle while o_busy is low
// training after set_end runs E epochs over n rows of m features each,
// with a bit divider forming each mean gradient
// the m+1 results then follow on consecutive cycles, the receiver cannot stall
// synchronous active-low reset; sample stores are not cleared
// ----------------------------------------------------------------------------
// linear_regression_gd_trainer
// batch gradient descent trainer for linear regression, Q16.16 fixed point
// ----------------------------------------------------------------------------
module linear_regression_gd_trainer #(
    parameter int MAX_FEATURES = 8,
    parameter int MAX_SAMPLES  = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_start,
    input  lrgd_pkg::t_item   i_item,
    output logic              o_busy,
    output logic              o_valid,
    output lrgd_pkg::t_result o_result
);
    import lrgd_pkg::*;

    t_cmd    cmd;
    t_status status;

    // control sequencer
    lrgd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_set_end (i_item.set_end),
        .i_status  (status),
        .o_cmd     (cmd),
        .o_busy    (o_busy)
    );

    // datapath
    lrgd_dp #(
        .MAX_FEATURES (MAX_FEATURES),
        .MAX_SAMPLES  (MAX_SAMPLES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_item),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

endmodule

@@ rtl/core/lrgd_div.sv @@
// ----------------------------------------------------------------------------
// lrgd_div
// signed by unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lrgd_div #(
    parameter int NW = 9
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [31:0]   i_dividend,
    input  logic [NW-1:0]        i_divisor,
    output logic                 o_done,
    output logic signed [32:0]   o_quotient
);
    logic [NW:0]   r_rem;
    logic [31:0]   r_quo;
    logic [NW-1:0] r_dsr;
    logic [5:0]    r_cnt;
    logic          r_busy;
    logic          r_done;
    logic          r_neg;
    logic [NW:0]   n_trial;
    logic [NW:0]   n_shift;

    // trial subtract of the shifted remainder
    always_comb begin
        n_shift = {r_rem[NW-1:0], r_quo[31]};
        n_trial = n_shift - {1'b0, r_dsr};
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // magnitude datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend[31] ? 32'(-i_dividend) : 32'(i_dividend);
            r_dsr <= i_divisor;
            r_neg <= i_dividend[31];
        end else if (r_busy) begin
            if (!n_trial[NW]) begin
                r_rem <= n_trial;
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= n_shift;
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});

endmodule

@@ rtl/core/lrgd_ctrl.sv @@
// ----------------------------------------------------------------------------
// lrgd_ctrl
// sequencer for loading, training epochs and coefficient output
// ----------------------------------------------------------------------------
module lrgd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_set_end,
    input  lrgd_pkg::t_status i_status,
    output lrgd_pkg::t_cmd    o_cmd,
    output logic              o_busy
);
    import lrgd_pkg::*;

    localparam logic [3:0] S_LOAD     = 4'd0;
    localparam logic [3:0] S_INIT     = 4'd1;
    localparam logic [3:0] S_P_RD     = 4'd2;
    localparam logic [3:0] S_P_MUL    = 4'd3;
    localparam logic [3:0] S_P_ACC    = 4'd4;
    localparam logic [3:0] S_G_RD     = 4'd5;
    localparam logic [3:0] S_G_ERR    = 4'd6;
    localparam logic [3:0] S_G_MUL    = 4'd7;
    localparam logic [3:0] S_G_ACC    = 4'd8;
    localparam logic [3:0] S_DIV_GO   = 4'd9;
    localparam logic [3:0] S_DIV_WAIT = 4'd10;
    localparam logic [3:0] S_STEP     = 4'd11;
    localparam logic [3:0] S_UPD      = 4'd12;
    localparam logic [3:0] S_EMIT     = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       n_load;

    assign n_load = i_start && (r_state == S_LOAD);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD:     if (n_load && i_set_end) n_state = S_INIT;
            S_INIT: begin
                if (i_status.set_empty || i_status.epochs_zero) n_state = S_EMIT;
                else n_state = S_P_RD;
            end
            S_P_RD:     n_state = S_P_MUL;
            S_P_MUL:    n_state = S_P_ACC;
            S_P_ACC: begin
                if (i_status.col_last && i_status.row_last) n_state = S_G_RD;
                else n_state = S_P_RD;
            end
            S_G_RD:     n_state = S_G_ERR;
            S_G_ERR:    n_state = S_G_MUL;
            S_G_MUL:    n_state = S_G_ACC;
            S_G_ACC: begin
                if (i_status.row_last) n_state = S_DIV_GO;
                else n_state = S_G_RD;
            end
            S_DIV_GO:   n_state = S_DIV_WAIT;
            S_DIV_WAIT: if (i_status.div_done) n_state = S_STEP;
            S_STEP:     n_state = S_UPD;
            S_UPD: begin
                if (!i_status.col_bias) n_state = S_G_RD;
                else if (i_status.epoch_last) n_state = S_EMIT;
                else n_state = S_P_RD;
            end
            S_EMIT:     if (i_status.col_bias) n_state = S_LOAD;
            default:    n_state = S_LOAD;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // command decode
    always_comb begin
        o_cmd.load      = n_load;
        o_cmd.div_start = (r_state == S_DIV_GO);
        case (r_state)
            S_INIT:     o_cmd.op = OP_INIT;
            S_P_RD:     o_cmd.op = OP_P_RD;
            S_P_MUL:    o_cmd.op = OP_P_MUL;
            S_P_ACC:    o_cmd.op = OP_P_ACC;
            S_G_RD:     o_cmd.op = OP_G_RD;
            S_G_ERR:    o_cmd.op = OP_G_ERR;
            S_G_MUL:    o_cmd.op = OP_G_MUL;
            S_G_ACC:    o_cmd.op = OP_G_ACC;
            S_DIV_GO:   o_cmd.op = OP_DIV;
            S_DIV_WAIT: o_cmd.op = OP_DIV;
            S_STEP:     o_cmd.op = OP_STEP;
            S_UPD:      o_cmd.op = OP_UPD;
            S_EMIT:     o_cmd.op = OP_EMIT;
            default:    o_cmd.op = OP_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_LOAD);

endmodule

@@ rtl/core/lrgd_dp.sv @@
// ----------------------------------------------------------------------------
// lrgd_dp
// sample stores, coefficients, multiply-accumulate and update arithmetic
// ----------------------------------------------------------------------------
module lrgd_dp #(
    parameter int MAX_FEATURES = 8,
    parameter int MAX_SAMPLES  = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    input  lrgd_pkg::t_item   i_item,
    input  lrgd_pkg::t_cmd    i_cmd,
    output lrgd_pkg::t_status o_status,
    output logic              o_valid,
    output lrgd_pkg::t_result o_result
);
    import lrgd_pkg::*;

    localparam int CW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int MW = $clog2(MAX_FEATURES + 1);
    localparam int KW = (MW > 4) ? MW : 4;
    localparam int RW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int NW = $clog2(MAX_SAMPLES + 1);
    localparam int SDEPTH = MAX_SAMPLES * (1 << CW);

    // configuration
    logic [15:0] r_lr;
    logic [15:0] r_epochs;
    logic [3:0]  r_fc;

    // stores
    logic signed [31:0] r_smem [SDEPTH];
    logic signed [31:0] r_tmem [MAX_SAMPLES];
    logic signed [31:0] r_pmem [MAX_SAMPLES];
    logic signed [31:0] r_x_q;
    logic signed [31:0] r_t_q;
    logic signed [31:0] r_p_q;

    // coefficients and counters
    logic signed [31:0] r_w [1 << CW];
    logic signed [31:0] r_bias;
    logic [CW-1:0]      r_load_pos;
    logic [NW-1:0]      r_count;
    logic [RW-1:0]      r_row;
    logic [MW-1:0]      r_col;
    logic [15:0]        r_epoch;

    // arithmetic pipeline registers
    logic signed [63:0] r_prod;
    logic signed [31:0] r_acc;
    logic signed [31:0] r_err;
    logic signed [31:0] r_g;
    logic signed [49:0] r_step;
    logic               r_out_valid;
    t_result            r_out;

    logic [MW-1:0]      n_m;
    logic [KW-1:0]      n_fc_ext;
    logic [MW-1:0]      n_col_eff;
    logic               n_row_end;
    logic               n_room;
    logic signed [31:0] n_sum;
    logic signed [31:0] n_term;
    logic signed [31:0] n_coef;
    logic signed [31:0] n_new_coef;
    logic signed [34:0] n_diff;
    logic               n_row_last;
    logic               n_col_last;
    logic               n_col_bias;
    logic               div_done;
    logic signed [32:0] div_quo;

    // effective feature count
    always_comb begin
        n_fc_ext = KW'(r_fc);
        if (n_fc_ext == '0) n_m = MW'(1);
        else if (n_fc_ext > KW'(MAX_FEATURES)) n_m = MW'(MAX_FEATURES);
        else n_m = MW'(n_fc_ext);
    end

    // load column and row end
    always_comb begin
        n_col_eff = (MW'(r_load_pos) >= n_m) ? n_m - MW'(1) : MW'(r_load_pos);
        n_row_end = (n_col_eff == n_m - MW'(1));
        n_room    = (r_count < NW'(MAX_SAMPLES));
    end

    // status
    always_comb begin
        n_row_last = ((NW'(r_row) + NW'(1)) == r_count);
        n_col_last = (r_col == n_m - MW'(1));
        n_col_bias = (r_col == n_m);
        o_status.row_last    = n_row_last;
        o_status.col_last    = n_col_last;
        o_status.col_bias    = n_col_bias;
        o_status.epoch_last  = (r_epoch == r_epochs - 16'd1);
        o_status.set_empty   = (r_count == '0);
        o_status.epochs_zero = (r_epochs == 16'd0);
        o_status.div_done    = div_done;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr     <= LR_RESET;
            r_epochs <= EPOCH_RESET;
            r_fc     <= FC_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LEARNING_RATE: r_lr     <= i_cfg_data;
                CFG_EPOCH_COUNT:   r_epochs <= i_cfg_data;
                CFG_FEATURE_COUNT: r_fc     <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // sample store
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && n_room) begin
            r_smem[{r_count[RW-1:0], n_col_eff[CW-1:0]}] <= i_item.feature_value;
        end
        r_x_q <= r_smem[{r_row, r_col[CW-1:0]}];
    end

    // target store
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && n_room && n_row_end) begin
            r_tmem[r_count[RW-1:0]] <= i_item.target_value;
        end
        r_t_q <= r_tmem[r_row];
    end

    // prediction store
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_P_ACC && n_col_last) begin
            r_pmem[r_row] <= n_sum;
        end
        r_p_q <= r_pmem[r_row];
    end

    // combinational arithmetic
    always_comb begin
        n_sum      = sadd(r_acc, qsat(r_prod));
        n_term     = n_col_bias ? r_err : qsat(r_prod);
        n_coef     = n_col_bias ? r_bias : r_w[r_col[CW-1:0]];
        n_diff     = {{3{n_coef[31]}}, n_coef} - {r_step[49], r_step[49:16]};
        if (n_diff[34:31] == 4'b0000 || n_diff[34:31] == 4'b1111) begin
            n_new_coef = n_diff[31:0];
        end else begin
            n_new_coef = n_diff[34] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
    end

    // loading counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_pos <= '0;
            r_count    <= '0;
        end else if (i_cmd.load) begin
            if (n_row_end) begin
                r_load_pos <= '0;
                if (n_room) r_count <= r_count + NW'(1);
            end else begin
                r_load_pos <= CW'(n_col_eff + MW'(1));
            end
        end else if (i_cmd.op == OP_EMIT && n_col_bias) begin
            r_load_pos <= '0;
            r_count    <= '0;
        end
    end

    // training counters and coefficients
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_epoch <= '0;
            r_bias  <= '0;
            for (int k = 0; k < (1 << CW); k++) r_w[k] <= '0;
        end else begin
            case (i_cmd.op)
                OP_INIT: begin
                    r_row   <= '0;
                    r_col   <= '0;
                    r_epoch <= '0;
                    r_bias  <= '0;
                    for (int k = 0; k < (1 << CW); k++) r_w[k] <= '0;
                end
                OP_P_ACC: begin
                    if (n_col_last) begin
                        r_col <= '0;
                        r_row <= n_row_last ? '0 : r_row + RW'(1);
                    end else begin
                        r_col <= r_col + MW'(1);
                    end
                end
                OP_G_ACC: begin
                    r_row <= n_row_last ? '0 : r_row + RW'(1);
                end
                OP_UPD: begin
                    if (n_col_bias) begin
                        r_bias  <= n_new_coef;
                        r_col   <= '0;
                        r_epoch <= r_epoch + 16'd1;
                    end else begin
                        r_w[r_col[CW-1:0]] <= n_new_coef;
                        r_col <= r_col + MW'(1);
                    end
                end
                OP_EMIT: begin
                    r_col <= n_col_bias ? '0 : r_col + MW'(1);
                end
                default: ;
            endcase
        end
    end

    // arithmetic registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_P_RD:  if (r_col == '0) r_acc <= r_bias;
            OP_P_MUL: r_prod <= r_x_q * r_w[r_col[CW-1:0]];
            OP_P_ACC: r_acc <= n_sum;
            OP_G_RD:  if (r_row == '0) r_g <= '0;
            OP_G_ERR: r_err <= sat33({r_p_q[31], r_p_q} - {r_t_q[31], r_t_q});
            OP_G_MUL: r_prod <= r_err * r_x_q;
            OP_G_ACC: r_g <= sadd(r_g, n_term);
            OP_STEP:  r_step <= $signed({1'b0, r_lr}) * div_quo;
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (i_cmd.op == OP_EMIT);
        end
        if (i_cmd.op == OP_EMIT) begin
            r_out.coefficient       <= n_coef;
            r_out.coefficient_index <= 4'(r_col);
            r_out.last              <= n_col_bias;
        end
    end

    // mean gradient divider
    lrgd_div #(
        .NW (NW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_g),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

@@ rtl/core/lrgd_checker.sv @@
// ----------------------------------------------------------------------------
// lrgd_checker
// port-level checks of the result burst and the busy handshake
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lrgd_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_start,
    input lrgd_pkg::t_item   i_item,
    input logic              o_busy,
    input logic              o_valid,
    input lrgd_pkg::t_result o_result
);
    // the bias transaction closes the burst
    `ASSERT_NEXT(a_last_valid, i_clk, i_rst_n, o_valid && o_result.last, !o_valid)

    // results of a run come on consecutive cycles
    `ASSERT_NEXT(a_burst, i_clk, i_rst_n, o_valid && !o_result.last, o_valid)

    // indexes count up inside a burst
    `ASSERT_NEXT(a_index_step, i_clk, i_rst_n, o_valid && !o_result.last, o_result.coefficient_index == 4'($past(o_result.coefficient_index) + 4'd1))

    // an item without set_end keeps the block accepting
    `ASSERT_NEXT(a_load_idle, i_clk, i_rst_n, i_start && !o_busy && !i_item.set_end, !o_busy)

    // only the bias result is shown once the block is idle again
    `ASSERT_IMPLIES(a_idle_last, i_clk, i_rst_n, o_valid && !o_busy, o_result.last)

endmodule

bind linear_regression_gd_trainer lrgd_checker u_chk (.*);
